### sv/erc_pkg.sv
// Shared types and constants for the elevator request controller.
// No dependencies; every other file refers to it by scoped names.
package erc_pkg;

  localparam int FLOOR_COUNT = 4;
  localparam int BTN_TYPES   = 3;
  localparam int REQ_BITS    = FLOOR_COUNT * BTN_TYPES;
  localparam int IDX_W       = $clog2(REQ_BITS);
  localparam int FLOOR_W     = 2;
  localparam int SENSOR_W    = 3;
  localparam int TICK_W      = 20;
  localparam int CFG_IDX_W   = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DOOR_OPEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVER   = CFG_IDX_W'(1);

  localparam logic [TICK_W-1:0] DOOR_OPEN_RESET = TICK_W'(300);
  localparam logic [TICK_W-1:0] RECOVER_RESET   = TICK_W'(300);

  typedef enum logic [3:0] {
    MODE_RCHECK    = 4'd0,
    MODE_RWAIT     = 4'd1,
    MODE_DESCEND   = 4'd2,
    MODE_SCAN      = 4'd3,
    MODE_SERVE     = 4'd4,
    MODE_DOOR_OB1  = 4'd5,
    MODE_DOOR_TIME = 4'd6,
    MODE_DOOR_OB2  = 4'd7,
    MODE_STOP_FLR  = 4'd8,
    MODE_STOP_MID  = 4'd9,
    MODE_STOP_DOOR = 4'd10
  } mode_e;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_UP   = 2'd1,
    DRV_DOWN = 2'd2
  } drive_e;

  typedef struct packed {
    logic signed [SENSOR_W-1:0] floor_sensor;
    logic [REQ_BITS-1:0]        call_buttons;
    logic                       stop_pressed;
    logic                       door_blocked;
  } in_word_t;

  typedef struct packed {
    logic [1:0]          motor_drive;
    logic [REQ_BITS-1:0] button_lamps;
    logic [FLOOR_W-1:0]  floor_lamp;
    logic                door_lamp;
    logic                stop_lamp;
  } out_word_t;

  typedef struct packed {
    logic [TICK_W-1:0] door_open_ticks;
    logic [TICK_W-1:0] recover_wait_ticks;
  } cfg_t;

  // request bit lookup; indexes past the request vector read as clear
  function automatic logic req_bit(input logic [REQ_BITS-1:0] vec,
                                   input logic [IDX_W-1:0] idx);
    logic r;
    r = 1'b0;
    if (idx < IDX_W'(REQ_BITS)) begin
      r = vec[idx];
    end
    return r;
  endfunction

endpackage

### sv/erc_ctrl.sv
// Mode machine, request latch and door/recovery timer of the controller.
// Depends on erc_pkg; steps once for every word presented with step_i high.
module erc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  erc_pkg::in_word_t word_i,
  input  erc_pkg::cfg_t     cfg_i,
  output erc_pkg::out_word_t result_o
);

  logic [erc_pkg::REQ_BITS-1:0] pend_q, pend_d, pend_lat;
  logic [erc_pkg::IDX_W-1:0]    scan_q, scan_d, scan_nxt;
  erc_pkg::mode_e               mode_q, mode_d;
  logic [erc_pkg::TICK_W-1:0]   tick_q, tick_d, tick_inc;
  logic [erc_pkg::FLOOR_W-1:0]  shown_q, shown_d;
  logic [erc_pkg::IDX_W-1:0]    served_q, served_d;
  erc_pkg::drive_e              drive_q, drive_d;

  logic                         fl_valid;
  logic [erc_pkg::FLOOR_W-1:0]  fl;
  logic [erc_pkg::IDX_W-1:0]    base;
  logic                         latch_en;
  logic                         in_door;

  assign fl_valid = !word_i.floor_sensor[erc_pkg::SENSOR_W-1] &&
                    (int'(word_i.floor_sensor) < erc_pkg::FLOOR_COUNT);
  assign fl       = fl_valid ? word_i.floor_sensor[erc_pkg::FLOOR_W-1:0] : '0;
  assign base     = erc_pkg::IDX_W'(fl) * erc_pkg::IDX_W'(erc_pkg::BTN_TYPES);
  assign tick_inc = tick_q + erc_pkg::TICK_W'(1);
  assign scan_nxt = (scan_q + erc_pkg::IDX_W'(1) >= erc_pkg::IDX_W'(erc_pkg::REQ_BITS)) ?
                    '0 : scan_q + erc_pkg::IDX_W'(1);

  // buttons latch only in scanning, serving, door and stop-door modes
  assign latch_en = (mode_q >= erc_pkg::MODE_SCAN) && (mode_q != erc_pkg::MODE_STOP_FLR) &&
                    (mode_q != erc_pkg::MODE_STOP_MID);
  assign pend_lat = latch_en ? (pend_q | word_i.call_buttons) : pend_q;

  // next state
  always_comb begin
    pend_d   = pend_q;
    scan_d   = scan_q;
    mode_d   = mode_q;
    tick_d   = tick_q;
    shown_d  = fl_valid ? fl : shown_q;
    served_d = served_q;
    drive_d  = drive_q;
    if (word_i.stop_pressed) begin
      if (mode_q != erc_pkg::MODE_STOP_FLR && mode_q != erc_pkg::MODE_STOP_MID) begin
        pend_d  = '0;
        drive_d = erc_pkg::DRV_STOP;
        mode_d  = fl_valid ? erc_pkg::MODE_STOP_FLR : erc_pkg::MODE_STOP_MID;
      end
    end else begin
      pend_d = pend_lat;
      unique case (mode_q)
        erc_pkg::MODE_RCHECK: begin
          if (fl_valid) begin
            mode_d = erc_pkg::MODE_SCAN;
          end else begin
            tick_d = '0;
            mode_d = erc_pkg::MODE_RWAIT;
          end
        end
        erc_pkg::MODE_RWAIT: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.recover_wait_ticks) begin
            mode_d  = erc_pkg::MODE_DESCEND;
            drive_d = erc_pkg::DRV_DOWN;
          end
        end
        erc_pkg::MODE_DESCEND: begin
          if (fl_valid) begin
            drive_d = erc_pkg::DRV_STOP;
            mode_d  = erc_pkg::MODE_SCAN;
          end else begin
            drive_d = erc_pkg::DRV_DOWN;
          end
        end
        erc_pkg::MODE_SCAN: begin
          drive_d = erc_pkg::DRV_STOP;
          if (!fl_valid) begin
            tick_d = '0;
            mode_d = erc_pkg::MODE_RWAIT;
          end else if (erc_pkg::req_bit(pend_lat, scan_q)) begin
            mode_d = erc_pkg::MODE_SERVE;
          end else begin
            scan_d = scan_nxt;
          end
        end
        erc_pkg::MODE_SERVE: begin
          if (!erc_pkg::req_bit(pend_lat, scan_q)) begin
            scan_d = scan_nxt;
            mode_d = erc_pkg::MODE_SCAN;
          end else if (fl_valid) begin
            if (scan_q < base) begin
              // target below: take hall-down or cab requests on the way
              if (erc_pkg::req_bit(pend_lat, base + erc_pkg::IDX_W'(1))) begin
                served_d = base + erc_pkg::IDX_W'(1);
                drive_d  = erc_pkg::DRV_STOP;
                mode_d   = erc_pkg::MODE_DOOR_OB1;
              end else if (erc_pkg::req_bit(pend_lat, base + erc_pkg::IDX_W'(2))) begin
                served_d = base + erc_pkg::IDX_W'(2);
                drive_d  = erc_pkg::DRV_STOP;
                mode_d   = erc_pkg::MODE_DOOR_OB1;
              end else begin
                drive_d = erc_pkg::DRV_DOWN;
              end
            end else if (scan_q >= base + erc_pkg::IDX_W'(erc_pkg::BTN_TYPES)) begin
              // target above: take hall-up or cab requests on the way
              if (erc_pkg::req_bit(pend_lat, base)) begin
                served_d = base;
                drive_d  = erc_pkg::DRV_STOP;
                mode_d   = erc_pkg::MODE_DOOR_OB1;
              end else if (erc_pkg::req_bit(pend_lat, base + erc_pkg::IDX_W'(2))) begin
                served_d = base + erc_pkg::IDX_W'(2);
                drive_d  = erc_pkg::DRV_STOP;
                mode_d   = erc_pkg::MODE_DOOR_OB1;
              end else begin
                drive_d = erc_pkg::DRV_UP;
              end
            end else begin
              served_d = scan_q;
              drive_d  = erc_pkg::DRV_STOP;
              mode_d   = erc_pkg::MODE_DOOR_OB1;
            end
          end
        end
        erc_pkg::MODE_DOOR_OB1: begin
          if (!word_i.door_blocked) begin
            tick_d = '0;
            mode_d = erc_pkg::MODE_DOOR_TIME;
          end
        end
        erc_pkg::MODE_DOOR_TIME: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.door_open_ticks) begin
            mode_d = erc_pkg::MODE_DOOR_OB2;
          end
        end
        erc_pkg::MODE_DOOR_OB2: begin
          if (!word_i.door_blocked) begin
            pend_d = pend_lat & ~(erc_pkg::REQ_BITS'(1) << served_q);
            mode_d = erc_pkg::MODE_SERVE;
          end
        end
        erc_pkg::MODE_STOP_FLR: begin
          tick_d = '0;
          mode_d = erc_pkg::MODE_STOP_DOOR;
        end
        erc_pkg::MODE_STOP_DOOR: begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.door_open_ticks) begin
            mode_d = erc_pkg::MODE_SCAN;
          end
        end
        default: begin
          mode_d = erc_pkg::MODE_SCAN;
        end
      endcase
    end
  end

  // result word, taken from the updated state
  always_comb begin
    in_door = (mode_d == erc_pkg::MODE_DOOR_OB1) || (mode_d == erc_pkg::MODE_DOOR_TIME) ||
              (mode_d == erc_pkg::MODE_DOOR_OB2);
    result_o.motor_drive  = drive_d;
    result_o.button_lamps = in_door ? (pend_d & ~(erc_pkg::REQ_BITS'(1) << served_d)) : pend_d;
    result_o.floor_lamp   = shown_d;
    result_o.door_lamp    = in_door || (mode_d == erc_pkg::MODE_STOP_FLR) ||
                            (mode_d == erc_pkg::MODE_STOP_DOOR);
    result_o.stop_lamp    = word_i.stop_pressed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      scan_q   <= '0;
      mode_q   <= erc_pkg::MODE_RCHECK;
      tick_q   <= '0;
      shown_q  <= '0;
      served_q <= '0;
      drive_q  <= erc_pkg::DRV_STOP;
    end else if (step_i) begin
      pend_q   <= pend_d;
      scan_q   <= scan_d;
      mode_q   <= mode_d;
      tick_q   <= tick_d;
      shown_q  <= shown_d;
      served_q <= served_d;
      drive_q  <= drive_d;
    end
  end

endmodule

### sv/erc_out_stage.sv
// Result register of the controller, holds a word while downstream stalls.
// Depends on erc_pkg.
module erc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  erc_pkg::out_word_t word_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output erc_pkg::out_word_t out_word_o
);

  logic               valid_q, valid_d;
  erc_pkg::out_word_t word_q;

  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

### sv/elevator_request_controller.sv
// Top level of the elevator request controller: input register, settings
// registers, mode machine and result register. Depends on erc_pkg, erc_ctrl
// and erc_out_stage.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid_i/in_stall_o  in_word_i  (erc_pkg::in_word_t)
//   out       source     out_valid_o/out_stall_i out_word_o (erc_pkg::out_word_t)
//   cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One poll word per clock while the output is not stalled. A word accepted
// into the input register is processed by the mode logic in erc_ctrl and
// lands in the result register once that register is free or draining; the
// input register can accept a new word as it does so.
// Reset puts the car in the recovery check with no requests and both timers at
// 300 polls. The input side stalls only when the input register is full and the
// result register is held by a downstream stall.
module elevator_request_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  erc_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output erc_pkg::out_word_t            out_word_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [erc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [erc_pkg::TICK_W-1:0]    cfg_data_i
);

  logic               in_valid_q, in_valid_d;
  erc_pkg::in_word_t  in_word_q;
  logic               in_take;
  logic               step;
  erc_pkg::cfg_t      cfg_q, cfg_d;
  erc_pkg::out_word_t result;

  // advance the held word when the result register is free or draining
  assign step       = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_o && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  // settings registers, always ready; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        erc_pkg::CFG_DOOR_OPEN: cfg_d.door_open_ticks    = cfg_data_i;
        erc_pkg::CFG_RECOVER:   cfg_d.recover_wait_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.door_open_ticks    <= erc_pkg::DOOR_OPEN_RESET;
      cfg_q.recover_wait_ticks <= erc_pkg::RECOVER_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  erc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (in_word_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  erc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .word_i      (result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

### sv/erc_checker.sv
// Port-level checks for the elevator request controller, bound to the top.
// Depends on erc_pkg and elevator_request_controller.
module erc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input erc_pkg::out_word_t out_word_o
);

  // a stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed under stall");

  // the motor is stopped whenever stop is held
  a_stop_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.stop_lamp |-> out_word_o.motor_drive == erc_pkg::DRV_STOP)
    else $error("motor driven while stop is held");

  // the motor is stopped whenever the door is open
  a_door_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.door_lamp |-> out_word_o.motor_drive == erc_pkg::DRV_STOP)
    else $error("motor driven with the door open");

  // no undefined motor command
  a_motor_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.motor_drive != 2'd3)
    else $error("undefined motor command");

endmodule

bind elevator_request_controller erc_checker u_erc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
